// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL, compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/ami_pkg.sv =====
// Types, constants and helper functions for the affine matrix inverse.
package ami_pkg;

  localparam int W     = 32;          // Q16.16 word
  localparam int FRAC  = 16;
  localparam int NLANE = 6;
  localparam int DW    = 2 * W - 1;   // |determinant| < 2^63
  localparam int NW    = 2 * W + FRAC; // numerator magnitude
  localparam int QW    = W + 1;       // quotient bits kept
  localparam int HW    = NW - QW;     // numerator bits above the quotient window

  localparam int LANE_R00 = 0;
  localparam int LANE_R01 = 1;
  localparam int LANE_R02 = 2;
  localparam int LANE_R10 = 3;
  localparam int LANE_R11 = 4;
  localparam int LANE_R12 = 5;

  localparam logic [W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [W-1:0] Q_ZERO  = 32'h0000_0000;
  localparam logic [W-1:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic          neg;   // result sign
    logic          ovf;   // quotient >= 2^33
    logic [DW-1:0] rem;
    logic [QW-1:0] lo;    // low numerator bits, quotient bits shift in
  } lane_t;

  typedef struct packed {
    logic [DW-1:0]          den;
    logic                   zero;
    lane_t [NLANE-1:0]      lane;
  } divst_t;

  function automatic logic [W-1:0] abs32(logic [W-1:0] x);
    return x[W-1] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [2*W-1:0] abs65(logic [2*W:0] x);
    logic [2*W:0] t;
    t = x[2*W] ? (~x + 65'd1) : x;
    return t[2*W-1:0];
  endfunction

  // one restoring step: bring down the next numerator bit
  function automatic lane_t div_step(lane_t x, logic [DW-1:0] den);
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    lane_t       y;
    trial = {x.rem, x.lo[QW-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
    y     = x;
    y.rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    y.lo  = {x.lo[QW-2:0], ge};
    return y;
  endfunction

endpackage

// ===== rtl/affine_matrix_inverse.sv =====
// Top level: pipelined inverse of a 2x3 affine matrix in Q16.16.
// Throughput: one matrix per cycle unless the spare skid entry is full.
// Pipeline: multiply, determinant, magnitude, divider setup, 33 one-bit
// divider stages, saturation, output register.
// A two-entry output skid lets the pipeline run while a result waits.
// Reset: synchronous active-low rst_n clears all valid bits.
`include "assert_macros.svh"

module affine_matrix_inverse import ami_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [NLANE*W-1:0]   in_tdata,   // m00, m01, m02, m10, m11, m12
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [NLANE*W-1:0]   out_tdata,  // r00, r01, r02, r10, r11, r12
  output logic [1:0]           out_tuser   // singular, clipped
);

  logic en;
  logic push;
  logic pop;

  logic signed [W-1:0] m [NLANE];

  // stage 1: products
  logic                  v1_r;
  logic signed [2*W-1:0] p_ae_r, p_bd_r, p_bf_r, p_ce_r, p_af_r, p_cd_r;
  logic signed [W-1:0]   a1_r, b1_r, d1_r, e1_r;

  // stage 2: determinant and translation cofactors
  logic                v2_r;
  logic signed [2*W:0] det2_r, cof0_2_r, cof1_2_r;
  logic signed [W-1:0] a2_r, b2_r, d2_r, e2_r;

  // stage 3: magnitudes
  logic          v3_r;
  logic [DW-1:0] den3_r;
  logic          zero3_r;
  logic [NW-1:0] num3_r [NLANE];
  logic          neg3_r [NLANE];

  logic [NW-1:0] num3_nxt [NLANE];
  logic          nneg_nxt [NLANE];
  logic          den_neg;
  logic [2*W-1:0] det_abs;

  // divider stages
  logic   dvv_r [QW+1];
  divst_t dv_r  [QW+1];
  divst_t dv_nxt [QW+1];

  // final stage
  logic          fin_valid_r;
  logic [W-1:0]  fin_res_r [NLANE];
  logic          fin_sing_r;
  logic          fin_clip_r;
  logic [W-1:0]  fin_res_nxt [NLANE];
  logic          fin_clip_nxt;

  // output skid
  logic          out_valid_r;
  logic [W-1:0]  out_res_r [NLANE];
  logic          out_sing_r;
  logic          out_clip_r;
  logic          spare_valid_r;
  logic [W-1:0]  spr_res_r [NLANE];
  logic          spr_sing_r;
  logic          spr_clip_r;

  assign en        = !spare_valid_r;
  assign in_tready = en;
  assign push      = en && fin_valid_r;
  assign pop       = out_valid_r && out_tready;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      m[k] = in_tdata[k*W +: W];
    end
  end

  // stage 3 combinational
  always_comb begin
    den_neg = det2_r[2*W];
    det_abs = abs65(det2_r);
    num3_nxt[LANE_R00] = {{(NW-2*W){1'b0}}, abs32(e2_r), {W{1'b0}}};
    num3_nxt[LANE_R01] = {{(NW-2*W){1'b0}}, abs32(b2_r), {W{1'b0}}};
    num3_nxt[LANE_R10] = {{(NW-2*W){1'b0}}, abs32(d2_r), {W{1'b0}}};
    num3_nxt[LANE_R11] = {{(NW-2*W){1'b0}}, abs32(a2_r), {W{1'b0}}};
    num3_nxt[LANE_R02] = {abs65(cof0_2_r), {FRAC{1'b0}}};
    num3_nxt[LANE_R12] = {abs65(cof1_2_r), {FRAC{1'b0}}};
    nneg_nxt[LANE_R00] = e2_r[W-1];
    nneg_nxt[LANE_R01] = !b2_r[W-1] && (b2_r != '0);
    nneg_nxt[LANE_R10] = !d2_r[W-1] && (d2_r != '0);
    nneg_nxt[LANE_R11] = a2_r[W-1];
    nneg_nxt[LANE_R02] = cof0_2_r[2*W];
    nneg_nxt[LANE_R12] = cof1_2_r[2*W];
  end

  // divider setup and steps
  always_comb begin
    dv_nxt[0].den  = den3_r;
    dv_nxt[0].zero = zero3_r;
    for (int k = 0; k < NLANE; k++) begin
      dv_nxt[0].lane[k].neg = neg3_r[k];
      dv_nxt[0].lane[k].ovf =
        {{(DW-HW){1'b0}}, num3_r[k][NW-1:QW]} >= den3_r;
      dv_nxt[0].lane[k].rem = {{(DW-HW){1'b0}}, num3_r[k][NW-1:QW]};
      dv_nxt[0].lane[k].lo  = num3_r[k][QW-1:0];
    end
    for (int s = 1; s <= QW; s++) begin
      dv_nxt[s] = dv_r[s-1];
      for (int k = 0; k < NLANE; k++) begin
        dv_nxt[s].lane[k] = div_step(dv_r[s-1].lane[k], dv_r[s-1].den);
      end
    end
  end

  // sign, saturation, singular override
  always_comb begin
    fin_clip_nxt = 1'b0;
    for (int k = 0; k < NLANE; k++) begin
      if (dv_r[QW].zero) begin
        fin_res_nxt[k] = (k == LANE_R00 || k == LANE_R11) ? Q_ONE : Q_ZERO;
      end else if (dv_r[QW].lane[k].neg) begin
        if (dv_r[QW].lane[k].ovf || dv_r[QW].lane[k].lo > {1'b0, SAT_NEG}) begin
          fin_res_nxt[k] = SAT_NEG;
          fin_clip_nxt   = 1'b1;
        end else begin
          fin_res_nxt[k] = ~dv_r[QW].lane[k].lo[W-1:0] + 32'd1;
        end
      end else begin
        if (dv_r[QW].lane[k].ovf || dv_r[QW].lane[k].lo > {1'b0, SAT_POS}) begin
          fin_res_nxt[k] = SAT_POS;
          fin_clip_nxt   = 1'b1;
        end else begin
          fin_res_nxt[k] = dv_r[QW].lane[k].lo[W-1:0];
        end
      end
    end
  end

  // pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      fin_valid_r <= 1'b0;
      for (int s = 0; s <= QW; s++) begin
        dvv_r[s] <= 1'b0;
      end
    end else if (en) begin
      v1_r   <= in_tvalid;
      p_ae_r <= m[0] * m[4];
      p_bd_r <= m[1] * m[3];
      p_bf_r <= m[1] * m[5];
      p_ce_r <= m[2] * m[4];
      p_af_r <= m[0] * m[5];
      p_cd_r <= m[2] * m[3];
      a1_r   <= m[0];
      b1_r   <= m[1];
      d1_r   <= m[3];
      e1_r   <= m[4];

      v2_r     <= v1_r;
      det2_r   <= (2*W+1)'(p_ae_r) - (2*W+1)'(p_bd_r);
      cof0_2_r <= (2*W+1)'(p_bf_r) - (2*W+1)'(p_ce_r);
      cof1_2_r <= (2*W+1)'(p_cd_r) - (2*W+1)'(p_af_r);
      a2_r     <= a1_r;
      b2_r     <= b1_r;
      d2_r     <= d1_r;
      e2_r     <= e1_r;

      v3_r    <= v2_r;
      den3_r  <= det_abs[DW-1:0];
      zero3_r <= (det2_r == '0);
      for (int k = 0; k < NLANE; k++) begin
        num3_r[k] <= num3_nxt[k];
        neg3_r[k] <= nneg_nxt[k] ^ den_neg;
      end

      dvv_r[0] <= v3_r;
      dv_r[0]  <= dv_nxt[0];
      for (int s = 1; s <= QW; s++) begin
        dvv_r[s] <= dvv_r[s-1];
        dv_r[s]  <= dv_nxt[s];
      end

      fin_valid_r <= dvv_r[QW];
      fin_sing_r  <= dv_r[QW].zero;
      fin_clip_r  <= fin_clip_nxt;
      for (int k = 0; k < NLANE; k++) begin
        fin_res_r[k] <= fin_res_nxt[k];
      end
    end
  end

  // output register with one spare entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
        out_sing_r  <= fin_sing_r;
        out_clip_r  <= fin_clip_r;
        for (int k = 0; k < NLANE; k++) begin
          out_res_r[k] <= fin_res_r[k];
        end
      end else begin
        spare_valid_r <= 1'b1;
        spr_sing_r    <= fin_sing_r;
        spr_clip_r    <= fin_clip_r;
        for (int k = 0; k < NLANE; k++) begin
          spr_res_r[k] <= fin_res_r[k];
        end
      end
    end else if (pop) begin
      if (spare_valid_r) begin
        spare_valid_r <= 1'b0;
        out_sing_r    <= spr_sing_r;
        out_clip_r    <= spr_clip_r;
        for (int k = 0; k < NLANE; k++) begin
          out_res_r[k] <= spr_res_r[k];
        end
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_clip_r, out_sing_r};

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      out_tdata[k*W +: W] = out_res_r[k];
    end
  end

  `ASSERT_CLK(a_spare_needs_out, spare_valid_r |-> out_valid_r && !in_tready, "spare item without output item")
  `ASSERT_NEVER(a_sing_clip, out_valid_r && out_sing_r && out_clip_r, "singular result flagged clipped")
  `ASSERT_CLK(a_sing_ident, out_valid_r && out_sing_r |-> out_res_r[LANE_R00] == Q_ONE && out_res_r[LANE_R11] == Q_ONE && out_res_r[LANE_R01] == Q_ZERO && out_res_r[LANE_R12] == Q_ZERO, "singular result is not identity")
  `ASSERT_CLK(a_fin_hold, fin_valid_r && !en |=> fin_valid_r, "stalled item lost from final stage")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the affine matrix inverse with random stream stalls.
`timescale 1ns / 1ps

module tb;
  import ami_pkg::*;

  typedef struct packed {
    logic [W-1:0] m12, m11, m10, m02, m01, m00;
  } affine_t;

  typedef struct packed {
    logic [W-1:0] r12, r11, r10, r02, r01, r00;
  } imat_t;

  typedef struct {
    imat_t m;
    logic  singular;
    logic  clipped;
  } inverse_t;

  localparam int IMIN     = 32'h8000_0000;
  localparam int IMAX     = 32'h7fff_ffff;
  localparam int N_RANDOM = 1035;
  localparam int LIMIT    = 200000;
  localparam int DRAIN    = 60;

  localparam logic signed [127:0] QMAX = 128'sd2147483647;
  localparam logic signed [127:0] QMIN = -QMAX - 128'sd1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [NLANE*W-1:0]   in_tdata = '0;   // m00, m01, m02, m10, m11, m12
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [NLANE*W-1:0]   out_tdata;       // r00, r01, r02, r10, r11, r12
  logic [1:0]           out_tuser;       // singular, clipped

  affine_t  matrices_to_send[$];
  inverse_t pending_inverses[$];
  int       n_total = 0;
  int       n_acc = 0;
  int       errors = 0;
  int       cycles = 0;

  affine_matrix_inverse u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // exact quotient, truncated toward zero, saturated to 32 bits
  function automatic inverse_t affine_inverse(affine_t x);
    logic signed [127:0] a, b, c, d, e, f, det, q;
    logic signed [127:0] num [NLANE];
    logic [W-1:0]        r [NLANE];
    inverse_t            y;
    int                  k;
    a = $signed(x.m00);
    b = $signed(x.m01);
    c = $signed(x.m02);
    d = $signed(x.m10);
    e = $signed(x.m11);
    f = $signed(x.m12);
    det = a * e - b * d;
    y.singular = (det == 0);
    y.clipped = 1'b0;
    if (det == 0) begin
      y.m = {Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE};
      return y;
    end
    num[LANE_R00] = e <<< 32;
    num[LANE_R01] = (-b) <<< 32;
    num[LANE_R02] = (b * f - c * e) <<< 16;
    num[LANE_R10] = (-d) <<< 32;
    num[LANE_R11] = a <<< 32;
    num[LANE_R12] = (c * d - a * f) <<< 16;
    for (k = 0; k < NLANE; k++) begin
      q = num[k] / det;
      if (q > QMAX) begin
        r[k] = SAT_POS;
        y.clipped = 1'b1;
      end else if (q < QMIN) begin
        r[k] = SAT_NEG;
        y.clipped = 1'b1;
      end else begin
        r[k] = q[W-1:0];
      end
    end
    y.m = {r[LANE_R12], r[LANE_R11], r[LANE_R10], r[LANE_R02], r[LANE_R01], r[LANE_R00]};
    return y;
  endfunction

  function automatic int idle_pct(bit sender);
    int ph;
    if (n_total == 0) return 0;
    ph = n_acc * 3 / n_total;
    if (ph == 0) return sender ? 24 : 79;
    if (ph == 1) return sender ? 79 : 24;
    return 0;
  endfunction

  function automatic int rand_word();
    int mag;
    case ($urandom_range(0, 3))
      0: return int'($urandom);
      1: return int'($urandom) >>> $urandom_range(1, 31);
      2: begin
        mag = int'($urandom_range(0, 1 << 19));
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return 0;
          1: return 1;
          2: return -1;
          3: return int'(Q_ONE);
          4: return IMIN;
          default: return IMAX;
        endcase
      end
    endcase
  endfunction

  function automatic int rand_factor();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic add_mat(int a, int b, int c, int d, int e, int f);
    matrices_to_send.push_back(affine_t'({f, e, d, c, b, a}));
  endtask

  task automatic cmp_field(string name, logic [W-1:0] want, logic [W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // driver: holds an item until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_inverses.push_back(affine_inverse(affine_t'(in_tdata)));
        n_acc <= n_acc + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (matrices_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_tdata <= matrices_to_send.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check
    inverse_t want;
    imat_t    got;
    out_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_inverses.size() == 0) begin
        $error("result item with no matrix pending");
        errors++;
      end else begin
        want = pending_inverses.pop_front();
        got = imat_t'(out_tdata);
        cmp_field("r00", want.m.r00, got.r00);
        cmp_field("r01", want.m.r01, got.r01);
        cmp_field("r02", want.m.r02, got.r02);
        cmp_field("r10", want.m.r10, got.r10);
        cmp_field("r11", want.m.r11, got.r11);
        cmp_field("r12", want.m.r12, got.r12);
        cmp_field("singular", W'(want.singular), W'(out_tuser[0]));
        cmp_field("clipped", W'(want.clipped), W'(out_tuser[1]));
      end
    end
  end

  initial begin
    int i, sel, a, b, c, d, e, f, p, q, x, y;

    // directed
    add_mat(int'(Q_ONE), 0, 0, 0, int'(Q_ONE), 0);
    add_mat(0, 0, 0, 0, 0, 0);
    add_mat(IMAX, IMAX, IMAX, IMAX, IMAX, IMAX);
    add_mat(IMIN, IMIN, IMIN, IMIN, IMIN, IMIN);
    add_mat(IMIN, 0, 0, 0, IMIN, 0);
    add_mat(1, 0, 0, 0, 1, 0);
    add_mat(0, 1, 0, 1, 0, 0);
    add_mat(8, 0, 0, 16, 4, 0);                 // r10 lands exactly on the negative limit
    add_mat(8, 0, 0, -16, 4, 0);
    add_mat(2, 1, IMAX, 4, 2, IMIN);            // singular, nonzero entries
    add_mat(-1, -1, -1, -1, -1, -1);
    add_mat(int'(Q_ONE), 0, IMAX, 0, int'(Q_ONE), IMIN);
    add_mat(0, -int'(Q_ONE), 32'h3_0000, int'(Q_ONE), 0, -32'sh2_0000);
    add_mat(32'h2_0000, 0, int'(Q_ONE), 0, 32'h2_0000, int'(Q_ONE));
    add_mat(IMAX, IMIN, 1, IMIN, IMAX, -1);
    add_mat(IMIN, IMAX, 0, IMAX, IMIN, 0);
    add_mat(int'(Q_ONE), 32'h2_0000, 7, 32'h3_0000, int'(Q_ONE), -5);

    for (i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 99);
      c = rand_word();
      f = rand_word();
      if (sel < 60) begin
        a = rand_word();
        b = rand_word();
        d = rand_word();
        e = rand_word();
      end else if (sel < 90) begin
        p = rand_factor();
        q = rand_factor();
        x = rand_factor();
        y = rand_factor();
        a = x * p;
        b = x * q;
        d = y * p;
        e = y * q;
        if (sel >= 75) e = e + int'($urandom_range(0, 32)) - 16;   // tiny determinant
      end else begin
        a = rand_word();
        b = 0;
        d = 0;
        e = rand_word();
      end
      add_mat(a, b, c, d, e, f);
    end
    n_total = matrices_to_send.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while ((matrices_to_send.size() != 0 || in_tvalid || pending_inverses.size() != 0)
           && cycles < LIMIT)
      @(negedge clk);
    if (cycles < LIMIT) repeat (DRAIN) @(negedge clk);

    if (cycles >= LIMIT)
      $display("Simulation FAILED");
    else if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ami_pkg.sv
rtl/affine_matrix_inverse.sv
sim/tb.sv
